@@ design/ofmt_pkg.sv @@
// Package for the octal field formatter.
// Holds the stream widths, character codes, length modes and the
// controller/datapath command and status types. No dependencies.
package ofmt_pkg;

    localparam int IN_W     = 88;
    localparam int OUT_W    = 16;
    localparam int LEN_W    = 7;
    localparam int FIELD_W  = 7;
    localparam int NDIG_W   = 5;
    localparam int NDIG_MAX = 22;
    localparam int DIG_W    = 3 * NDIG_MAX;

    localparam logic [2:0] MODE_8     = 3'd0;
    localparam logic [2:0] MODE_16    = 3'd1;
    localparam logic [2:0] MODE_32    = 3'd2;
    localparam logic [2:0] MODE_LONG  = 3'd3;
    localparam logic [2:0] MODE_LLONG = 3'd4;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_SPACE = 7'h20;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_ZERO,
        PH_DIGIT,
        PH_TRAIL
    } phase_t;

    typedef struct packed {
        logic   load;
        logic   scan_step;
        logic   prep;
        logic   emit;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic cur_zero;
        logic last;
        logic out_free;
    } status_t;

endpackage

@@ design/octal_field_formatter.sv @@
// Octal field formatter, top level: joins the controller and the datapath.
// Depends on ofmt_pkg, ofmt_ctrl and ofmt_datapath.
//
// One request is taken at a time and turned into its printf-style octal text,
// one ASCII character per output transfer. After a request is accepted the
// block shifts off the leading zero octal digits of the truncated value to
// find the digit count, sizes the padding, zero and digit segments, then
// sends the characters segment by segment, passing over empty segments;
// a stalled output holds back the next character. The next request is
// accepted in the cycle after the last character is loaded into the output
// register, so the output register lets it in while that character waits.
// A request that yields no character produces no output transfer.
module octal_field_formatter #(
    parameter int MAX_FIELD = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // value[63:0], length_mode[66:64], field_width[73:67], precision[80:74],
    // precision_given[81], flag_zero[82], flag_alternate[83], flag_left[84]
    input  logic [ofmt_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // char_code[6:0], total_length[13:7]
    output logic [ofmt_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tlast
);
    import ofmt_pkg::*;

    cmd_t    cmd;
    status_t status;

    ofmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ofmt_datapath #(
        .MAX_FIELD (MAX_FIELD)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ design/ofmt_datapath.sv @@
// Datapath of the octal field formatter: request registers, digit scan,
// segment counts and the output register.
// Depends on ofmt_pkg.
module ofmt_datapath #(
    parameter int MAX_FIELD = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ofmt_pkg::IN_W-1:0]  s_tdata,
    input  ofmt_pkg::cmd_t             cmd,
    output ofmt_pkg::status_t          status,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [ofmt_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tlast
);
    import ofmt_pkg::*;

    localparam logic [7:0] MAX_F = 8'(MAX_FIELD);

    logic [63:0]        in_value;
    logic [2:0]         in_mode;
    logic [FIELD_W-1:0] in_width;
    logic [FIELD_W-1:0] in_prec;
    logic               in_pgiven;
    logic [63:0]        trunc_value;
    logic [FIELD_W-1:0] sat_width;
    logic [FIELD_W-1:0] sat_prec;

    logic [DIG_W-1:0]   digits_reg;
    logic [NDIG_W-1:0]  ndig_reg;
    logic [FIELD_W-1:0] width_reg;
    logic [FIELD_W-1:0] prec_reg;
    logic               pgiven_reg;
    logic               fzero_reg;
    logic               falt_reg;
    logic               fleft_reg;
    logic               nz_reg;
    logic [FIELD_W-1:0] lead_reg;
    logic [FIELD_W-1:0] zcnt_reg;
    logic [FIELD_W-1:0] trail_reg;
    logic [LEN_W-1:0]   total_reg;

    logic               out_valid_reg;
    logic [6:0]         out_char_reg;
    logic               out_last_reg;
    logic [LEN_W-1:0]   out_len_reg;

    logic [7:0]         w8;
    logic [7:0]         n8;
    logic [7:0]         p8;
    logic [7:0]         zf_pad;
    logic [7:0]         nm_zeros;
    logic [7:0]         nm_body;
    logic [7:0]         nm_pad;
    logic               empty_path;
    logic [FIELD_W-1:0] lead_next;
    logic [FIELD_W-1:0] zcnt_next;
    logic [FIELD_W-1:0] trail_next;
    logic [NDIG_W-1:0]  ndig_next;
    logic [6:0]         emit_char;
    logic [LEN_W-1:0]   total_next;

    assign in_value  = s_tdata[63:0];
    assign in_mode   = s_tdata[66:64];
    assign in_width  = s_tdata[73:67];
    assign in_prec   = s_tdata[80:74];
    assign in_pgiven = s_tdata[81];

    always_comb
    begin
        case (in_mode)
            MODE_8:  trunc_value = {56'd0, in_value[7:0]};
            MODE_16: trunc_value = {48'd0, in_value[15:0]};
            MODE_32: trunc_value = {32'd0, in_value[31:0]};
            default: trunc_value = in_value;
        endcase
        sat_width = ({1'b0, in_width} > MAX_F) ? MAX_F[FIELD_W-1:0] : in_width;
        if (!in_pgiven)
            sat_prec = '0;
        else
            sat_prec = ({1'b0, in_prec} > MAX_F) ? MAX_F[FIELD_W-1:0] : in_prec;
    end

    // segment sizes for the three paths
    always_comb
    begin
        w8 = {1'b0, width_reg};
        n8 = {3'b0, ndig_reg};
        p8 = {1'b0, prec_reg};
        zf_pad   = (w8 > n8) ? (w8 - n8) : 8'd0;
        nm_zeros = (p8 > n8) ? (p8 - n8) : 8'd0;
        if (nz_reg && falt_reg && (nm_zeros == 8'd0))
            nm_zeros = 8'd1;
        nm_body = nm_zeros + n8;
        nm_pad  = (w8 > nm_body) ? (w8 - nm_body) : 8'd0;
        empty_path = pgiven_reg && (prec_reg == '0) && !nz_reg;
        ndig_next  = ndig_reg;
        if (fzero_reg)
        begin
            lead_next  = '0;
            zcnt_next  = zf_pad[FIELD_W-1:0]
                       + FIELD_W'(nz_reg && falt_reg && (zf_pad == 8'd0));
            trail_next = '0;
        end
        else if (empty_path)
        begin
            lead_next  = width_reg;
            zcnt_next  = '0;
            trail_next = '0;
            ndig_next  = '0;
        end
        else
        begin
            lead_next  = fleft_reg ? '0 : nm_pad[FIELD_W-1:0];
            zcnt_next  = nm_zeros[FIELD_W-1:0];
            trail_next = fleft_reg ? nm_pad[FIELD_W-1:0] : '0;
        end
    end

    always_comb
    begin
        status.scan_done = (digits_reg[DIG_W-1 -: 3] != 3'd0) || (ndig_reg == NDIG_W'(1));
        status.out_free  = !out_valid_reg || m_tready;
        case (cmd.phase)
            PH_LEAD:
            begin
                status.cur_zero = (lead_reg == '0);
                status.last = (lead_reg == FIELD_W'(1)) && (zcnt_reg == '0)
                            && (ndig_reg == '0) && (trail_reg == '0);
                emit_char = CHAR_SPACE;
            end
            PH_ZERO:
            begin
                status.cur_zero = (zcnt_reg == '0);
                status.last = (zcnt_reg == FIELD_W'(1)) && (ndig_reg == '0)
                            && (trail_reg == '0);
                emit_char = CHAR_ZERO;
            end
            PH_DIGIT:
            begin
                status.cur_zero = (ndig_reg == '0);
                status.last = (ndig_reg == NDIG_W'(1)) && (trail_reg == '0);
                emit_char = CHAR_ZERO + {4'd0, digits_reg[DIG_W-1 -: 3]};
            end
            default:
            begin
                status.cur_zero = (trail_reg == '0);
                status.last = (trail_reg == FIELD_W'(1));
                emit_char = CHAR_SPACE;
            end
        endcase
        total_next = total_reg + LEN_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            digits_reg <= {2'b00, trunc_value};
            ndig_reg   <= NDIG_W'(NDIG_MAX);
            width_reg  <= sat_width;
            prec_reg   <= sat_prec;
            pgiven_reg <= in_pgiven;
            fzero_reg  <= s_tdata[82];
            falt_reg   <= s_tdata[83];
            fleft_reg  <= s_tdata[84];
            nz_reg     <= (trunc_value != 64'd0);
            total_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            digits_reg <= {digits_reg[DIG_W-4:0], 3'b000};
            ndig_reg   <= ndig_reg - NDIG_W'(1);
        end
        else if (cmd.prep)
        begin
            lead_reg  <= lead_next;
            zcnt_reg  <= zcnt_next;
            trail_reg <= trail_next;
            ndig_reg  <= ndig_next;
        end
        else if (cmd.emit)
        begin
            total_reg <= total_next;
            case (cmd.phase)
                PH_LEAD:  lead_reg <= lead_reg - FIELD_W'(1);
                PH_ZERO:  zcnt_reg <= zcnt_reg - FIELD_W'(1);
                PH_DIGIT:
                begin
                    digits_reg <= {digits_reg[DIG_W-4:0], 3'b000};
                    ndig_reg   <= ndig_reg - NDIG_W'(1);
                end
                default:  trail_reg <= trail_reg - FIELD_W'(1);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= status.last;
            out_len_reg  <= status.last ? total_next : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_len_reg, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ design/ofmt_ctrl.sv @@
// Controller of the octal field formatter: sequences accept, digit scan,
// segment setup and the four character segments.
// Depends on ofmt_pkg.
module ofmt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ofmt_pkg::status_t status,
    output ofmt_pkg::cmd_t    cmd
);
    import ofmt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_LEAD,
        S_ZERO,
        S_DIGIT,
        S_TRAIL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;
    logic   in_emit;

    always_comb
    begin
        case (state_reg)
            S_LEAD:  cmd.phase = PH_LEAD;
            S_ZERO:  cmd.phase = PH_ZERO;
            S_DIGIT: cmd.phase = PH_DIGIT;
            default: cmd.phase = PH_TRAIL;
        endcase
        in_emit = (state_reg == S_LEAD) || (state_reg == S_ZERO)
               || (state_reg == S_DIGIT) || (state_reg == S_TRAIL);
        cmd.load      = s_tvalid && s_tready_reg;
        cmd.scan_step = (state_reg == S_SCAN) && !status.scan_done;
        cmd.prep      = (state_reg == S_PREP);
        cmd.emit      = in_emit && !status.cur_zero && status.out_free;

        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (cmd.load) state_next = S_SCAN;
            S_SCAN:  if (status.scan_done) state_next = S_PREP;
            S_PREP:  state_next = S_LEAD;
            S_LEAD,
            S_ZERO,
            S_DIGIT,
            S_TRAIL:
            begin
                if (cmd.emit && status.last)
                    state_next = S_IDLE;
                else if (status.cur_zero)
                begin
                    case (state_reg)
                        S_LEAD:  state_next = S_ZERO;
                        S_ZERO:  state_next = S_DIGIT;
                        S_DIGIT: state_next = S_TRAIL;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

endmodule

@@ design/ofmt_checker.sv @@
// Port-level checks for the octal field formatter, bound to the top level.
// Depends on ofmt_pkg and octal_field_formatter.
module ofmt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [ofmt_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tlast
);
    import ofmt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    a_len_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[13:7] == '0)
        else $error("count shown before the last character");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[13:7] != '0)
        else $error("last character carries a zero count");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in progress");

    a_char_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:0] == CHAR_SPACE
                  || (m_tdata[6:0] >= CHAR_ZERO && m_tdata[6:0] <= CHAR_ZERO + 7'd7))
        else $error("character is neither a space nor an octal digit");

endmodule

bind octal_field_formatter ofmt_checker u_ofmt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ tb/octal_text_checker.sv @@
// Checker for the octal field formatter: expands each request accepted on the
// input stream into its expected characters and compares every output transfer.
// Depends on ofmt_pkg; instantiated beside the block by tb_octal_field_formatter.
module octal_text_checker #(
    parameter int MAX_FIELD = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [ofmt_pkg::IN_W-1:0]  s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [ofmt_pkg::OUT_W-1:0] m_tdata,
    input  logic                       m_tlast,
    output int                         error_count,
    output int                         pending
);
    import ofmt_pkg::*;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
        logic [6:0] total;
    } char_t;

    char_t expected_chars[$];

    initial
    begin
        error_count = 0;
        pending     = 0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch on %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
        error_count++;
    endtask

    // Builds the full octal text of one request and queues it.
    task automatic expand_octal(input logic [IN_W-1:0] req);
        logic [63:0] num;
        logic [2:0]  mode;
        int          width;
        int          prec;
        int          ndig;
        int          zeros;
        int          pad;
        int          d;
        logic        pgiven;
        logic        fzero;
        logic        falt;
        logic        fleft;
        logic [6:0]  text[$];
        char_t       c;

        num    = req[63:0];
        mode   = req[66:64];
        width  = int'(req[73:67]);
        pgiven = req[81];
        fzero  = req[82];
        falt   = req[83];
        fleft  = req[84];
        prec   = pgiven ? int'(req[80:74]) : 0;
        if (width > MAX_FIELD)
            width = MAX_FIELD;
        if (prec > MAX_FIELD)
            prec = MAX_FIELD;

        case (mode)
            MODE_8:  num = num & 64'hFF;
            MODE_16: num = num & 64'hFFFF;
            MODE_32: num = num & 64'hFFFF_FFFF;
            default: ;
        endcase

        ndig = 1;
        while (ndig < NDIG_MAX && (num >> (3 * ndig)) != 0)
            ndig++;

        if (fzero)
        begin
            pad = width > ndig ? width - ndig : 0;
            if (num != 0 && falt && pad == 0)
                text.push_back(CHAR_ZERO);
            repeat (pad) text.push_back(CHAR_ZERO);
            for (d = ndig - 1; d >= 0; d--)
                text.push_back(CHAR_ZERO + 7'((num >> (3 * d)) & 64'h7));
        end
        else if (pgiven && prec == 0 && num == 0)
        begin
            repeat (width) text.push_back(CHAR_SPACE);
        end
        else
        begin
            zeros = prec > ndig ? prec - ndig : 0;
            if (num != 0 && falt && zeros == 0)
                zeros = 1;
            pad = width > zeros + ndig ? width - zeros - ndig : 0;
            if (!fleft)
                repeat (pad) text.push_back(CHAR_SPACE);
            repeat (zeros) text.push_back(CHAR_ZERO);
            for (d = ndig - 1; d >= 0; d--)
                text.push_back(CHAR_ZERO + 7'((num >> (3 * d)) & 64'h7));
            if (fleft)
                repeat (pad) text.push_back(CHAR_SPACE);
        end

        for (d = 0; d < text.size(); d++)
        begin
            c.code  = text[d];
            c.last  = (d == text.size() - 1);
            c.total = c.last ? 7'(text.size()) : 7'd0;
            expected_chars.push_back(c);
        end
    endtask

    always @(posedge clk)
    begin : watch
        char_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch("unexpected transfer", m_tdata, 16'd0);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_tdata[6:0] !== want.code)
                        report_mismatch("char_code", 16'(m_tdata[6:0]), 16'(want.code));
                    if (m_tlast !== want.last)
                        report_mismatch("last_char", 16'(m_tlast), 16'(want.last));
                    if (m_tdata[13:7] !== want.total)
                        report_mismatch("total_length", 16'(m_tdata[13:7]),
                                        16'(want.total));
                end
            end
            if (s_tvalid && s_tready)
                expand_octal(s_tdata);
            pending <= expected_chars.size();
        end
    end

endmodule

@@ tb/tb_octal_field_formatter.sv @@
// Testbench top for octal_field_formatter: clock, reset, request stimulus and
// output back-pressure, with the verdict. Depends on ofmt_pkg,
// octal_field_formatter and octal_text_checker.
module tb_octal_field_formatter;
    import ofmt_pkg::*;

    localparam int MAX_FIELD  = 64;
    localparam int N_RANDOM   = 260;
    localparam int HOLD_AT    = 40;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN      = 150;
    localparam int LIMIT      = 500000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;

    int   error_count;
    int   pending;
    int   sent_count = 0;
    int   cycle_count = 0;
    logic quiet = 1'b0;
    logic rx_hold = 1'b0;

    octal_field_formatter #(.MAX_FIELD(MAX_FIELD)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    octal_text_checker #(.MAX_FIELD(MAX_FIELD)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .pending     (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] pack_request(
        input logic [63:0] value, input logic [2:0] mode,
        input logic [6:0] width, input logic [6:0] prec,
        input logic pg, input logic fz, input logic fa, input logic fl);
        return {3'b000, fl, fa, fz, pg, prec, width, mode, value};
    endfunction

    task automatic offer_request(input logic [IN_W-1:0] req);
        while (!quiet && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    function automatic logic [6:0] pick_field();
        return ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(24));
    endfunction

    // receiver back-pressure
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            m_tready <= !rx_hold && (quiet || $urandom_range(99) >= 22);
        end
    end

    // long receiver stall so the block fills up and stalls its input
    initial
    begin
        wait (sent_count == HOLD_AT);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin : stimulus
        logic [63:0] val;
        int          m;
        int          n;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain zero, empty conversions, saturated widths
        offer_request(pack_request(64'd0, MODE_8, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0));
        offer_request(pack_request(64'd0, MODE_8, 7'd0, 7'd0, 1'b1, 1'b0, 1'b1, 1'b0));
        offer_request(pack_request(64'd0, MODE_16, 7'd5, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1));
        offer_request(pack_request(64'd0, MODE_32, 7'd127, 7'd0, 1'b1, 1'b0, 1'b0, 1'b0));
        // all-ones value through every length mode, alternate form on odd modes
        for (m = 0; m < 8; m++)
            offer_request(pack_request('1, 3'(m), 7'd0, 7'd0, 1'b0, 1'b0, 1'(m), 1'b0));
        // zero-fill: padding suppresses the alternate zero, none keeps it
        offer_request(pack_request(64'd8, MODE_8, 7'd10, 7'd0, 1'b0, 1'b1, 1'b1, 1'b0));
        offer_request(pack_request(64'd8, MODE_8, 7'd2, 7'd0, 1'b0, 1'b1, 1'b1, 1'b0));
        offer_request(pack_request(64'd0, MODE_8, 7'd0, 7'd0, 1'b0, 1'b1, 1'b1, 1'b0));
        // zero-fill ignores precision and left-justify
        offer_request(pack_request(64'o1234, MODE_16, 7'd127, 7'd30, 1'b1, 1'b1, 1'b0, 1'b1));
        // normal path
        offer_request(pack_request(64'o123, MODE_32, 7'd20, 7'd5, 1'b1, 1'b0, 1'b1, 1'b1));
        offer_request(pack_request(64'o123, MODE_32, 7'd20, 7'd5, 1'b1, 1'b0, 1'b1, 1'b0));
        offer_request(pack_request('1, MODE_LLONG, 7'd127, 7'd127, 1'b1, 1'b0, 1'b1, 1'b0));
        offer_request(pack_request(64'd7, MODE_8, 7'd0, 7'd50, 1'b0, 1'b0, 1'b0, 1'b0));
        offer_request(pack_request(64'd0, MODE_8, 7'd3, 7'd0, 1'b0, 1'b0, 1'b1, 1'b0));
        offer_request(pack_request(64'd1, MODE_8, 7'd0, 7'd1, 1'b1, 1'b0, 1'b1, 1'b0));
        offer_request(pack_request('1, MODE_LONG, 7'd127, 7'd0, 1'b0, 1'b0, 1'b0, 1'b1));

        for (n = 0; n < N_RANDOM; n++)
        begin
            quiet <= (n >= 120 && n < 180);
            case ($urandom_range(3))
                0: val = {$urandom, $urandom};
                1: val = 64'($urandom_range(63));
                2: val = 64'd0;
                default: val = {$urandom, $urandom} >> $urandom_range(63);
            endcase
            offer_request(pack_request(val, 3'($urandom_range(7)), pick_field(), pick_field(),
                                       1'($urandom), 1'($urandom_range(3) == 0),
                                       1'($urandom), 1'($urandom)));
        end
        s_tvalid <= 1'b0;
        quiet    <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN) @(posedge clk);

        if (error_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
